// File: rtl/core/tdc_event_hit_decoder_top_defines.svh
// Assertion macros shared by the TDC event hit decoder RTL.
`ifndef TDC_EVENT_HIT_DECODER_TOP_DEFINES_SVH
`define TDC_EVENT_HIT_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TDC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tdc decoder check failed");
// condition must never be seen outside reset
`define TDC_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tdc decoder check failed");
`else
`define TDC_ASSERT(label, prop)
`define TDC_ASSERT_NEVER(label, cond)
`endif
`endif

// File: rtl/core/tdcd_pkg.sv
// Types and constants of the TDC event hit decoder.
package tdcd_pkg;

   localparam int DEF_CHANNELS        = 64;
   localparam int DEF_MAX_EVENT_WORDS = 65536;

   localparam int WORD_W  = 32;
   localparam int TIME_W  = 38;
   localparam int DELTA_W = 39;

   // one coarse tick in fine units, and the wrap period of the time stamp
   localparam logic [15:0]       COARSE_UNIT = 16'd53200;
   localparam logic [TIME_W-1:0] WRAP_TIME   = 38'd223136972800;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_HIT       = 3'd0,
      KIND_COUNT     = 3'd1,
      KIND_SIZE      = 3'd2,
      KIND_SHORT     = 3'd3,
      KIND_NO_HEADER = 3'd4
   } kind_type;

   // hit: word_a = hit word, word_b = extension word
   // error: word_a = got value, word_b = expected value
   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/core/tdcd_front.sv
// Front end: stream parser, event bookkeeping and classification into queue entries.
module tdcd_front import tdcd_pkg::*; #(
   parameter int MAX_EVENT_WORDS = DEF_MAX_EVENT_WORDS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [WORD_W-1:0] data_word,
   input  queue_status_type  status,
   output logic              push,
   output entry_type         push_entry
);

   localparam int WP_W = $clog2(MAX_EVENT_WORDS);
   localparam logic [WP_W-1:0] WP_LAST = WP_W'(MAX_EVENT_WORDS - 1);

   logic [WP_W-1:0]   wp_ff, wp_in;
   logic [13:0]       hlen_ff, hlen_in;
   logic [WORD_W-1:0] expected_ff, expected_in;
   logic              in_event_ff, in_event_in;
   logic [WORD_W-1:0] held_ff, held_in;

   logic              accept;
   logic [WP_W:0]     length;
   logic [WP_W-1:0]   wp_inc;

   assign accept = req_valid && !status.full;
   assign length = {1'b0, wp_ff} + (WP_W+1)'(1);
   assign wp_inc = wp_ff + WP_W'(1);

   // classify one accepted word
   always_comb begin
      wp_in       = wp_ff;
      hlen_in     = hlen_ff;
      expected_in = expected_ff;
      in_event_in = in_event_ff;
      held_in     = held_ff;
      push        = 1'b0;
      push_entry  = '{kind: KIND_HIT, word_a: '0, word_b: '0};

      if (accept) begin
         if (data_word[31]) begin
            // header: close the open event, then open a new one
            if (in_event_ff) begin
               if (length < (WP_W+1)'(3)) begin
                  push       = 1'b1;
                  push_entry = '{kind: KIND_SHORT, word_a: 32'(length),
                                 word_b: 32'(hlen_ff)};
               end else if (32'(length) != 32'(hlen_ff)) begin
                  push       = 1'b1;
                  push_entry = '{kind: KIND_SIZE, word_a: 32'(length),
                                 word_b: 32'(hlen_ff)};
               end
            end
            hlen_in     = data_word[15:2];
            wp_in       = '0;
            in_event_in = 1'b1;
         end else if (!in_event_ff) begin
            push       = 1'b1;
            push_entry = '{kind: KIND_NO_HEADER, word_a: data_word, word_b: '0};
         end else if (wp_ff < WP_LAST) begin
            wp_in = wp_inc;
            if (wp_inc == WP_W'(1)) begin
               // address/id word, not used
            end else if (wp_inc == WP_W'(2)) begin
               if (data_word != expected_ff) begin
                  push       = 1'b1;
                  push_entry = '{kind: KIND_COUNT, word_a: data_word,
                                 word_b: expected_ff};
               end
               expected_in = data_word + 32'd1;
            end else if (wp_inc[0]) begin
               held_in = data_word;
            end else begin
               push       = 1'b1;
               push_entry = '{kind: KIND_HIT, word_a: held_ff,
                              word_b: {16'b0, data_word[15:0]}};
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         hlen_ff     <= '0;
         expected_ff <= '1;
         in_event_ff <= 1'b0;
         held_ff     <= '0;
      end else begin
         wp_ff       <= wp_in;
         hlen_ff     <= hlen_in;
         expected_ff <= expected_in;
         in_event_ff <= in_event_in;
         held_ff     <= held_in;
      end
   end

endmodule

// File: rtl/core/tdcd_queue.sv
// Short queue of classified entries between front and back.
`include "tdc_event_hit_decoder_top_defines.svh"
module tdcd_queue import tdcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type              q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign head         = q_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `TDC_ASSERT_NEVER(a_no_overflow, push && !pop && status.full)
   `TDC_ASSERT_NEVER(a_no_underflow, pop && status.empty)
   `TDC_ASSERT(a_count_up, push && !pop |=> count_ff == QUEUE_CNT_W'($past(count_ff) + 1'b1))

endmodule

// File: rtl/core/tdcd_back.sv
// Back end: time stamp pipeline, per-channel last-time table and result register.
`include "tdc_event_hit_decoder_top_defines.svh"
module tdcd_back import tdcd_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  entry_type                 head,
   input  queue_status_type          status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kind_type                  rsp_kind,
   output logic [3:0]                rsp_module_addr,
   output logic [5:0]                rsp_channel,
   output logic                      rsp_edge_res,
   output logic [TIME_W-1:0]         rsp_hit_time,
   output logic signed [DELTA_W-1:0] rsp_delta,
   output logic [WORD_W-1:0]         rsp_got_value,
   output logic [WORD_W-1:0]         rsp_expected_value
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = -39'sd12334;
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 39'sd223136985134;

   logic advance;

   // channel table
   logic [TIME_W-1:0]   tbl_mem [CHANNELS];
   logic [CHANNELS-1:0] tbl_valid_ff;
   logic                tbl_we;

   // stage 1: product and table read
   logic              s1_valid_ff;
   entry_type         s1_entry_ff;
   logic [TIME_W-1:0] s1_prod_ff, s1_prod_in;
   logic [TIME_W-1:0] s1_rd_ff;
   logic              s1_rd_v_ff;

   // stage 2: time stamp and previous time
   logic                     s2_valid_ff;
   entry_type                s2_entry_ff;
   logic [TIME_W-1:0]        s2_t_ff, s2_t_in;
   logic [TIME_W-1:0]        s2_prev_ff, s2_prev_in;
   logic [DELTA_W-1:0]       s2_prev_mw_ff, s2_prev_mw_in;
   logic                     s2_in_table_ff, s2_in_table_in;

   // output register
   logic                      out_valid_ff;
   kind_type                  out_kind_ff;
   logic [3:0]                out_mod_ff, out_mod_in;
   logic [5:0]                out_ch_ff, out_ch_in;
   logic                      out_edge_ff, out_edge_in;
   logic [TIME_W-1:0]         out_time_ff, out_time_in;
   logic signed [DELTA_W-1:0] out_delta_ff, out_delta_in;
   logic [WORD_W-1:0]         out_got_ff, out_got_in;
   logic [WORD_W-1:0]         out_exp_ff, out_exp_in;

   logic [5:0]         head_ch, s1_ch, s2_ch;
   logic [IDX_W-1:0]   head_idx, s1_idx, s2_idx;
   logic [21:0]        head_coarse;
   logic               s1_in_table, fwd;
   logic [DELTA_W-1:0] diff0, diff1;

   // whole pipeline moves when the result register is free or being taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && !status.empty;

   // stage 1 inputs from queue head
   assign head_ch     = head.word_a[27:22];
   assign head_idx    = head_ch[IDX_W-1:0];
   assign head_coarse = {head.word_b[15:0], head.word_a[21:16]};
   assign s1_prod_in  = TIME_W'(head_coarse) * TIME_W'(COARSE_UNIT);

   // stage 1: time add, previous-time select with forward from stage 2
   assign s1_ch       = s1_entry_ff.word_a[27:22];
   assign s1_idx      = s1_ch[IDX_W-1:0];
   assign s2_ch       = s2_entry_ff.word_a[27:22];
   assign s2_idx      = s2_ch[IDX_W-1:0];
   assign s1_in_table = (s1_entry_ff.kind == KIND_HIT) && ({1'b0, s1_ch} < 7'(CHANNELS));
   assign fwd         = s2_valid_ff && s2_in_table_ff && (s2_idx == s1_idx);
   assign tbl_we      = advance && s1_valid_ff && s1_in_table;

   always_comb begin
      s2_t_in        = s1_prod_ff + TIME_W'({s1_entry_ff.word_a[15:1], 1'b0});
      s2_in_table_in = s1_in_table;
      if (fwd) begin
         s2_prev_in = s2_t_ff;
      end else if (s1_rd_v_ff) begin
         s2_prev_in = s1_rd_ff;
      end else begin
         s2_prev_in = '0;
      end
      s2_prev_mw_in = {1'b0, s2_prev_in} - {1'b0, WRAP_TIME};
   end

   // result stage: delta with wraparound, field selection
   assign diff0 = {1'b0, s2_t_ff} - {1'b0, s2_prev_ff};
   assign diff1 = {1'b0, s2_t_ff} - s2_prev_mw_ff;

   always_comb begin
      out_mod_in   = '0;
      out_ch_in    = '0;
      out_edge_in  = 1'b0;
      out_time_in  = '0;
      out_delta_in = '0;
      out_got_in   = '0;
      out_exp_in   = '0;
      if (s2_entry_ff.kind == KIND_HIT) begin
         out_mod_in  = s2_entry_ff.word_a[31:28];
         out_ch_in   = s2_ch;
         out_edge_in = s2_entry_ff.word_a[0];
         out_time_in = s2_t_ff;
         if (s2_in_table_ff) begin
            out_delta_in = diff0[DELTA_W-1] ? $signed(diff1) : $signed(diff0);
         end
      end else begin
         out_got_in = s2_entry_ff.word_a;
         out_exp_in = s2_entry_ff.word_b;
      end
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[s1_idx] <= s2_t_in;
      end
      if (advance) begin
         s1_rd_ff <= tbl_mem[head_idx];
      end
   end

   // table valid bits and read qualifier
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (tbl_we) begin
         tbl_valid_ff[s1_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rd_v_ff <= tbl_valid_ff[head_idx];
      end
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_entry_ff    <= head;
         s1_prod_ff     <= s1_prod_in;
         s2_entry_ff    <= s1_entry_ff;
         s2_t_ff        <= s2_t_in;
         s2_prev_ff     <= s2_prev_in;
         s2_prev_mw_ff  <= s2_prev_mw_in;
         s2_in_table_ff <= s2_in_table_in;
         out_kind_ff    <= s2_entry_ff.kind;
         out_mod_ff     <= out_mod_in;
         out_ch_ff      <= out_ch_in;
         out_edge_ff    <= out_edge_in;
         out_time_ff    <= out_time_in;
         out_delta_ff   <= out_delta_in;
         out_got_ff     <= out_got_in;
         out_exp_ff     <= out_exp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_module_addr    = out_mod_ff;
   assign rsp_channel        = out_ch_ff;
   assign rsp_edge_res       = out_edge_ff;
   assign rsp_hit_time       = out_time_ff;
   assign rsp_delta          = out_delta_ff;
   assign rsp_got_value      = out_got_ff;
   assign rsp_expected_value = out_exp_ff;

   `TDC_ASSERT(a_err_fields_zero, rsp_valid && rsp_kind != KIND_HIT |-> rsp_hit_time == '0 && rsp_delta == '0 && rsp_channel == '0)
   `TDC_ASSERT(a_delta_range, rsp_valid && rsp_kind == KIND_HIT |-> rsp_delta >= DELTA_MIN && rsp_delta <= DELTA_MAX)
   `TDC_ASSERT(a_write_sets_valid, tbl_we |=> tbl_valid_ff[$past(s1_idx)])

endmodule

// File: rtl/core/tdc_event_hit_decoder_top.sv
// An accepted word is classified, then registered in the queue, stage 1, stage 2 and the result register.
// Throughput: one word per cycle while req_stall is low; one table read and one table write
// per cycle while the pipeline advances, with a forward path for back-to-back hits on the same channel.
// req_stall rises only when the four-entry queue fills while results are stalled.
// Reset (synchronous, active high) clears event state, the queue, the pipeline and
// the channel table valid bits; the expected event count restarts at all ones.
module tdc_event_hit_decoder_top import tdcd_pkg::*; #(
   parameter int CHANNELS        = DEF_CHANNELS,
   parameter int MAX_EVENT_WORDS = DEF_MAX_EVENT_WORDS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [WORD_W-1:0]         req_data_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_kind,
   output logic [3:0]                rsp_module_addr,
   output logic [5:0]                rsp_channel,
   output logic                      rsp_edge_res,
   output logic [TIME_W-1:0]         rsp_hit_time,
   output logic signed [DELTA_W-1:0] rsp_delta,
   output logic [WORD_W-1:0]         rsp_got_value,
   output logic [WORD_W-1:0]         rsp_expected_value
);

   queue_status_type q_status;
   logic             q_push;
   entry_type        q_push_entry;
   logic             q_pop;
   entry_type        q_head;
   kind_type         kind;

   assign req_stall = q_status.full;
   assign rsp_kind  = kind;

   // parser and classifier
   tdcd_front #(
      .MAX_EVENT_WORDS (MAX_EVENT_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .data_word  (req_data_word),
      .status     (q_status),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // decoupling queue
   tdcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // time stamp and delta pipeline
   tdcd_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (q_head),
      .status             (q_status),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (kind),
      .rsp_module_addr    (rsp_module_addr),
      .rsp_channel        (rsp_channel),
      .rsp_edge_res       (rsp_edge_res),
      .rsp_hit_time       (rsp_hit_time),
      .rsp_delta          (rsp_delta),
      .rsp_got_value      (rsp_got_value),
      .rsp_expected_value (rsp_expected_value)
   );

endmodule
